// ===== rtl/core/lpg_pkg.sv =====
// Shared types, command codes and stream field positions for the line pixel generator.
package lpg_pkg;

    // Command codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_MOVE = 2'd0,
        CMD_LINE = 2'd1,
        CMD_STEP = 2'd2
    } cmd_t;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_ORIGIN_LEFT    = 3'd0,
        REG_ORIGIN_TOP     = 3'd1,
        REG_SURFACE_WIDTH  = 3'd2,
        REG_SURFACE_HEIGHT = 3'd3,
        REG_FORE_RED       = 3'd4,
        REG_FORE_GREEN     = 3'd5,
        REG_FORE_BLUE      = 3'd6
    } cfg_reg_t;

    // Surface-local coordinate, span and error widths
    typedef logic signed [16:0] coord_t;
    typedef logic signed [17:0] span_t;
    typedef logic signed [19:0] err_t;

    // Input item after origin removal
    typedef struct packed {
        logic [1:0] cmd;
        coord_t     walk_x;
        coord_t     walk_y;
        coord_t     goal_x;
        coord_t     goal_y;
    } front_t;

    // Stream widths
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 64;

    // Output tdata field positions
    localparam int PIXEL_X_LSB    = 0;
    localparam int PIXEL_Y_LSB    = 17;
    localparam int ON_SURFACE_BIT = 34;
    localparam int PIXEL_RGB_LSB  = 35;
    localparam int OUT_PAD_W      = 5;

endpackage

// ===== rtl/core/line_pixel_generator_unit.sv =====
// Bresenham line generator with pen position, clip flag and foreground color.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready with the command in s_tuser
//   (move pen, start line, step one pixel) and the target point in s_tdata.
//   A move sets the pen and gives no item. A line starts at the pen, moves
//   the pen to the target and gives the first pixel. Each step gives the
//   next pixel; the pixel at the end point has m_tlast set. A step with no
//   line in progress gives nothing, and a new line drops an unfinished one.
//   Results leave on m_tvalid/m_tready, m_tdata holding the local pixel,
//   the on-surface flag and the 24-bit color.
//   The user writes registers through cfg_wr_en/cfg_index/cfg_data only while idle; the block does not enforce it.
// Timing:
//   Two register stages: origin removal in the front stage, then the
//   Bresenham update and clip test into the output register. An item
//   passes through the front register and then the output register
//   before its pixel is handed off. One item per cycle is sustained while
//   m_tready is high; the error update loop closes in the second stage.
// Reset and stall:
//   Reset clears the pen, the stage valids and the drawing flag and loads the default registers.
//   When m_tready is low the output register holds; the front stage still
//   takes one more item, and items that give no pixel keep flowing.
module line_pixel_generator_unit #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [2:0]                        cfg_index,
    input  logic [15:0]                       cfg_data,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lpg_pkg::IN_TDATA_W-1:0]    s_tdata,   // target_h[15:0], target_v[31:16]
    input  logic [lpg_pkg::IN_TUSER_W-1:0]    s_tuser,   // cmd[1:0]
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lpg_pkg::OUT_TDATA_W-1:0]   m_tdata,   // pixel_x[16:0], pixel_y[33:17],
                                                         // on_surface[34], pixel_rgb[58:35]
    output logic                              m_tlast    // last_pixel
);

    localparam logic [16:0] SIDE_LIMIT = 17'(MAX_SIDE);

    // Configuration registers
    logic signed [15:0] origin_left_reg;
    logic signed [15:0] origin_top_reg;
    logic [12:0]        surface_width_reg;
    logic [12:0]        surface_height_reg;
    logic [7:0]         fore_red_reg;
    logic [7:0]         fore_green_reg;
    logic [7:0]         fore_blue_reg;

    // Pen and front stage
    logic signed [15:0] pen_x_reg;
    logic signed [15:0] pen_y_reg;
    logic               front_valid_reg;
    lpg_pkg::front_t    front_reg;
    lpg_pkg::front_t    front_next;

    // Line walk state
    lpg_pkg::coord_t    walk_x_reg, walk_x_next;
    lpg_pkg::coord_t    walk_y_reg, walk_y_next;
    lpg_pkg::coord_t    goal_x_reg, goal_x_next;
    lpg_pkg::coord_t    goal_y_reg, goal_y_next;
    lpg_pkg::span_t     span_x_reg, span_x_next;
    lpg_pkg::span_t     span_y_neg_reg, span_y_neg_next;
    logic               dir_x_neg_reg, dir_x_neg_next;
    logic               dir_y_neg_reg, dir_y_neg_next;
    lpg_pkg::err_t      error_term_reg, error_term_next;
    logic               drawing_reg, drawing_next;

    // Output register
    logic               out_valid_reg;
    lpg_pkg::coord_t    out_x_reg;
    lpg_pkg::coord_t    out_y_reg;
    logic               out_on_reg;
    logic [23:0]        out_rgb_reg;
    logic               out_last_reg;

    // Handshake and datapath signals
    logic               in_accept;
    logic               produce;
    logic               back_go;
    logic               line_cmd;
    logic               step_cmd;
    lpg_pkg::coord_t    target_h;
    lpg_pkg::coord_t    target_v;
    lpg_pkg::coord_t    pen_x_local;
    lpg_pkg::coord_t    pen_y_local;
    lpg_pkg::span_t     dx_raw;
    lpg_pkg::span_t     dy_raw;
    logic signed [20:0] e2;
    logic signed [20:0] span_x_wide;
    logic signed [20:0] span_y_neg_wide;
    logic               move_x;
    logic               move_y;
    lpg_pkg::err_t      add_x;
    lpg_pkg::err_t      add_y;
    lpg_pkg::coord_t    pix_x;
    lpg_pkg::coord_t    pix_y;
    logic [16:0]        side_w;
    logic [16:0]        side_h;
    logic               pix_on;

    // Handshake: the output register frees room whenever it is empty or taken
    assign line_cmd  = (front_reg.cmd == lpg_pkg::CMD_LINE);
    assign step_cmd  = (front_reg.cmd == lpg_pkg::CMD_STEP);
    assign produce   = line_cmd || (step_cmd && drawing_reg);
    assign back_go   = front_valid_reg && (!produce || !out_valid_reg || m_tready);
    assign s_tready  = !front_valid_reg || back_go;
    assign in_accept = s_tvalid && s_tready;

    // Make pen and target surface-local
    assign target_h    = {s_tdata[15], s_tdata[15:0]};
    assign target_v    = {s_tdata[31], s_tdata[31:16]};
    assign pen_x_local = {pen_x_reg[15], pen_x_reg} - {origin_left_reg[15], origin_left_reg};
    assign pen_y_local = {pen_y_reg[15], pen_y_reg} - {origin_top_reg[15], origin_top_reg};

    always_comb
    begin
        front_next.cmd    = s_tuser;
        front_next.walk_x = pen_x_local;
        front_next.walk_y = pen_y_local;
        front_next.goal_x = target_h - {origin_left_reg[15], origin_left_reg};
        front_next.goal_y = target_v - {origin_top_reg[15], origin_top_reg};
    end

    // Line setup terms
    assign dx_raw = {front_reg.goal_x[16], front_reg.goal_x}
                  - {front_reg.walk_x[16], front_reg.walk_x};
    assign dy_raw = {front_reg.goal_y[16], front_reg.goal_y}
                  - {front_reg.walk_y[16], front_reg.walk_y};

    // Step decision on the doubled error term
    assign e2              = {error_term_reg, 1'b0};
    assign span_x_wide     = {{3{span_x_reg[17]}}, span_x_reg};
    assign span_y_neg_wide = {{3{span_y_neg_reg[17]}}, span_y_neg_reg};
    assign move_x          = (e2 >= span_y_neg_wide);
    assign move_y          = (e2 <= span_x_wide);
    assign add_x = move_x ? {{2{span_y_neg_reg[17]}}, span_y_neg_reg} : '0;
    assign add_y = move_y ? {{2{span_x_reg[17]}}, span_x_reg} : '0;

    // Next line state for the item in the front stage
    always_comb
    begin
        walk_x_next     = walk_x_reg;
        walk_y_next     = walk_y_reg;
        goal_x_next     = goal_x_reg;
        goal_y_next     = goal_y_reg;
        span_x_next     = span_x_reg;
        span_y_neg_next = span_y_neg_reg;
        dir_x_neg_next  = dir_x_neg_reg;
        dir_y_neg_next  = dir_y_neg_reg;
        error_term_next = error_term_reg;
        drawing_next    = drawing_reg;
        if (line_cmd)
        begin
            walk_x_next     = front_reg.walk_x;
            walk_y_next     = front_reg.walk_y;
            goal_x_next     = front_reg.goal_x;
            goal_y_next     = front_reg.goal_y;
            dir_x_neg_next  = !(front_reg.walk_x < front_reg.goal_x);
            dir_y_neg_next  = !(front_reg.walk_y < front_reg.goal_y);
            span_x_next     = dir_x_neg_next ? -dx_raw : dx_raw;
            span_y_neg_next = dir_y_neg_next ? dy_raw : -dy_raw;
            error_term_next = {{2{span_x_next[17]}}, span_x_next}
                            + {{2{span_y_neg_next[17]}}, span_y_neg_next};
            drawing_next    = !((front_reg.walk_x == front_reg.goal_x)
                                && (front_reg.walk_y == front_reg.goal_y));
        end
        else if (step_cmd && drawing_reg)
        begin
            error_term_next = error_term_reg + add_x + add_y;
            if (move_x)
            begin
                walk_x_next = dir_x_neg_reg ? walk_x_reg - 17'sd1 : walk_x_reg + 17'sd1;
            end
            if (move_y)
            begin
                walk_y_next = dir_y_neg_reg ? walk_y_reg - 17'sd1 : walk_y_reg + 17'sd1;
            end
            drawing_next = !((walk_x_next == goal_x_reg) && (walk_y_next == goal_y_reg));
        end
    end

    // Clip test against the limited surface size
    assign pix_x  = walk_x_next;
    assign pix_y  = walk_y_next;
    assign side_w = ({4'b0, surface_width_reg} > SIDE_LIMIT) ? SIDE_LIMIT
                                                             : {4'b0, surface_width_reg};
    assign side_h = ({4'b0, surface_height_reg} > SIDE_LIMIT) ? SIDE_LIMIT
                                                              : {4'b0, surface_height_reg};
    assign pix_on = !pix_x[16] && !pix_y[16] && (pix_x[16:0] < side_w)
                    && (pix_y[16:0] < side_h);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_left_reg    <= '0;
            origin_top_reg     <= '0;
            surface_width_reg  <= 13'd640;
            surface_height_reg <= 13'd480;
            fore_red_reg       <= '0;
            fore_green_reg     <= '0;
            fore_blue_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lpg_pkg::REG_ORIGIN_LEFT:    origin_left_reg    <= cfg_data;
                lpg_pkg::REG_ORIGIN_TOP:     origin_top_reg     <= cfg_data;
                lpg_pkg::REG_SURFACE_WIDTH:  surface_width_reg  <= cfg_data[12:0];
                lpg_pkg::REG_SURFACE_HEIGHT: surface_height_reg <= cfg_data[12:0];
                lpg_pkg::REG_FORE_RED:       fore_red_reg       <= cfg_data[15:8];
                lpg_pkg::REG_FORE_GREEN:     fore_green_reg     <= cfg_data[15:8];
                lpg_pkg::REG_FORE_BLUE:      fore_blue_reg      <= cfg_data[15:8];
                default:                     ;
            endcase
        end
    end

    // Control: pen, stage valids and drawing flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg       <= '0;
            pen_y_reg       <= '0;
            front_valid_reg <= 1'b0;
            drawing_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // Move the pen on move and line items
            if (in_accept && ((s_tuser == lpg_pkg::CMD_MOVE) || (s_tuser == lpg_pkg::CMD_LINE)))
            begin
                pen_x_reg <= s_tdata[15:0];
                pen_y_reg <= s_tdata[31:16];
            end
            if (in_accept)
            begin
                front_valid_reg <= 1'b1;
            end
            else if (back_go)
            begin
                front_valid_reg <= 1'b0;
            end
            if (back_go)
            begin
                drawing_reg <= drawing_next;
            end
            if (back_go && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: front stage, walk state and output register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            front_reg <= front_next;
        end
        if (back_go)
        begin
            walk_x_reg     <= walk_x_next;
            walk_y_reg     <= walk_y_next;
            goal_x_reg     <= goal_x_next;
            goal_y_reg     <= goal_y_next;
            span_x_reg     <= span_x_next;
            span_y_neg_reg <= span_y_neg_next;
            dir_x_neg_reg  <= dir_x_neg_next;
            dir_y_neg_reg  <= dir_y_neg_next;
            error_term_reg <= error_term_next;
        end
        if (back_go && produce)
        begin
            out_x_reg    <= pix_x;
            out_y_reg    <= pix_y;
            out_on_reg   <= pix_on;
            out_rgb_reg  <= {fore_red_reg, fore_green_reg, fore_blue_reg};
            out_last_reg <= !drawing_next;
        end
    end

    // Drive the output stream
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{lpg_pkg::OUT_PAD_W{1'b0}}, out_rgb_reg, out_on_reg,
                       out_y_reg, out_x_reg};

endmodule

// ===== rtl/core/lpg_checker.sv =====
// Port-level checks for the line pixel generator, bound to the top level.
module lpg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lpg_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                              m_tlast
);

    // Stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result item changed");

    // Input is never blocked while the output register is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output register");

    // A fresh result follows an accepted input item through the front and output registers
    a_out_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result item without a matching input item");

    // Pixels flagged on the surface have non-negative coordinates
    a_on_surface_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[lpg_pkg::ON_SURFACE_BIT])
        |-> (!m_tdata[lpg_pkg::PIXEL_Y_LSB-1] && !m_tdata[lpg_pkg::ON_SURFACE_BIT-1]))
        else $error("on-surface pixel with negative coordinate");

endmodule

bind line_pixel_generator_unit lpg_checker u_lpg_checker (.*);
